>>> rtl/lcdfe_pkg.sv
// lcdfe_pkg: constants, frame layout and interface structs for the light channel block
// used by every module of the block; depends on nothing
`default_nettype none

package lcdfe_pkg;

  // channel table geometry (table depth must be a power of two)
  localparam int unsigned ChannelsPerUnit = 32;
  localparam int unsigned UnitCount       = 32;
  localparam int unsigned TableDepth      = UnitCount * ChannelsPerUnit;
  localparam int unsigned IdxW            = $clog2(TableDepth);

  // decay divider widths
  localparam int unsigned DvdW = 31;
  localparam int unsigned DvsW = 16;

  // fixed point constants
  localparam logic [15:0] OneQ15      = 16'h8000;
  localparam logic [15:0] MinFade     = 16'd100;
  localparam logic [22:0] FullScale   = 23'd7208960;     // 220 * 32768
  localparam logic [29:0] FullScale99 = 30'd713687040;   // 99 * 220 * 32768
  localparam logic [14:0] Recip55     = 15'd19066;       // ceil(2^20 / 55)
  localparam logic [7:0]  LevelFull   = 8'h01;
  localparam logic [7:0]  LevelDark   = 8'hF0;
  localparam logic [7:0]  LevelBase   = 8'd30;

  // dimmer command bytes
  localparam logic [7:0] FrameHdr      = 8'h00;
  localparam logic [7:0] FrameCmd      = 8'h03;
  localparam logic [3:0] FrameChanFlag = 4'h8;
  localparam logic [7:0] FrameTail     = 8'h00;

  // byte positions within a command
  typedef logic [2:0] pos_t;
  localparam pos_t PosHdr   = 3'd0;
  localparam pos_t PosUnit  = 3'd1;
  localparam pos_t PosCmd   = 3'd2;
  localparam pos_t PosLevel = 3'd3;
  localparam pos_t PosChan  = 3'd4;
  localparam pos_t PosTail  = 3'd5;

  typedef struct packed {
    logic            start;
    logic [DvdW-1:0] dividend;
    logic [DvsW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DvdW-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic            rd_en;
    logic            wr_en;
    logic [IdxW-1:0] addr;
    logic [15:0]     wdata;
  } mem_req_t;

  typedef struct packed {
    logic [4:0] unit;
    logic [7:0] level;
    logic [3:0] chan_code;
  } frame_t;

endpackage

`default_nettype wire

>>> rtl/lcdfe_div.sv
// lcdfe_div: restoring divider, one quotient bit per cycle
// depends on lcdfe_pkg for widths and request/response structs
`default_nettype none

module lcdfe_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lcdfe_pkg::div_req_t req_i,
  output lcdfe_pkg::div_rsp_t rsp_o
);
  import lcdfe_pkg::*;

  localparam int unsigned CntW = $clog2(DvdW);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DvdW-1:0] dvd_q, dvd_d;   // dividend shifts out, quotient shifts in
  logic [DvsW-1:0] dvs_q, dvs_d;
  logic [DvsW-1:0] rem_q, rem_d;
  logic [DvsW:0]   rem_sh;
  logic [DvsW:0]   diff;
  logic            fits;

  assign rem_sh = {rem_q, dvd_q[DvdW-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};
  assign fits   = ~diff[DvsW];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = fits ? diff[DvsW-1:0] : rem_sh[DvsW-1:0];
      dvd_d = {dvd_q[DvdW-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(DvdW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dvd_q;

endmodule

`default_nettype wire

>>> rtl/lcdfe_mem.sv
// lcdfe_mem: channel intensity memory, one port, registered read, cleared after reset
// depends on lcdfe_pkg for table depth and the request struct
`default_nettype none

module lcdfe_mem (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lcdfe_pkg::mem_req_t req_i,
  output logic [15:0]         rdata_o,
  output logic                ready_o
);
  import lcdfe_pkg::*;

  logic [15:0]     store_q [TableDepth];
  logic [15:0]     rdata_q;
  logic            clr_busy_q;
  logic [IdxW-1:0] clr_addr_q;
  logic            we;
  logic [IdxW-1:0] waddr;
  logic [15:0]     wdata;

  // clearing sweep owns the write port until it finishes
  assign we    = clr_busy_q | req_i.wr_en;
  assign waddr = clr_busy_q ? clr_addr_q : req_i.addr;
  assign wdata = clr_busy_q ? 16'd0 : req_i.wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == IdxW'(TableDepth - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      store_q[waddr] <= wdata;
    end
    if (req_i.rd_en) begin
      rdata_q <= store_q[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;
  assign ready_o = ~clr_busy_q;

endmodule

`default_nettype wire

>>> rtl/lcdfe_frm.sv
// lcdfe_frm: output register holding one dimmer command and sending it byte by byte
// depends on lcdfe_pkg for frame layout
`default_nettype none

module lcdfe_frm (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  lcdfe_pkg::frame_t frame_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        frame_byte_o,
  output logic              frame_last_o
);
  import lcdfe_pkg::*;

  logic   valid_q;
  pos_t   pos_q;
  frame_t frm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pos_q   <= PosHdr;
    end else if (!valid_q) begin
      if (load_i) begin
        valid_q <= 1'b1;
        pos_q   <= PosHdr;
      end
    end else if (out_ready_i) begin
      if (pos_q == PosTail) begin
        valid_q <= 1'b0;
      end else begin
        pos_q <= pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && !valid_q) begin
      frm_q <= frame_i;
    end
  end

  always_comb begin
    unique case (pos_q)
      PosHdr:   frame_byte_o = FrameHdr;
      PosUnit:  frame_byte_o = {3'b000, frm_q.unit};
      PosCmd:   frame_byte_o = FrameCmd;
      PosLevel: frame_byte_o = frm_q.level;
      PosChan:  frame_byte_o = {FrameChanFlag, frm_q.chan_code};
      default:  frame_byte_o = FrameTail;
    endcase
  end

  assign frame_last_o = (pos_q == PosTail);
  assign out_valid_o  = valid_q;
  assign free_o       = ~valid_q;

endmodule

`default_nettype wire

>>> rtl/light_channel_decay_and_frame_encode.sv
// light_channel_decay_and_frame_encode: per-channel intensity decay, peak hold and
// dimmer command encoding; uses lcdfe_pkg, lcdfe_mem, lcdfe_div and lcdfe_frm
//
//   channel | handshake               | payload
//   --------+-------------------------+------------------------------------------
//   in      | in_valid_i / in_ready_o | unit, channel, elapsed, fade, gain,
//           |                         | sample, min level, voltage, effect
//   out     | out_valid_o/out_ready_i | frame_byte_o, frame_last_o (6 per item)
//
// an item runs from its accept through the read, decay, scale and level states (and
// the reciprocal step when the level byte needs it) to the emit state that loads
// its command; the next item is accepted once the block is back in idle; the serial
// divider for the decay step sets the rate; the level byte uses compares and a
// multiply by the reciprocal of 55; after reset the 1024-entry intensity memory is
// zeroed one entry a cycle, so in_ready_o stays low until the sweep finishes
// the command register lets the next item start while six bytes drain; a stalled
// output only holds the block once a second command is ready to load
`default_nettype none

module light_channel_decay_and_frame_encode (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [4:0]  unit_number_i,
  input  logic [4:0]  channel_number_i,
  input  logic [15:0] elapsed_ms_i,
  input  logic [15:0] fade_ms_i,
  input  logic [15:0] gain_q8_i,
  input  logic [15:0] sample_q16_i,
  input  logic [15:0] min_level_q15_i,
  input  logic [7:0]  voltage_i,
  input  logic        effect_active_i,
  input  logic [15:0] effect_value_q15_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  frame_byte_o,
  output logic        frame_last_o
);
  import lcdfe_pkg::*;

  typedef enum logic [2:0] {
    StIdle,      // wait for an item, read its table entry
    StRead,      // entry arrives, start decay divide, form product
    StDecay,     // wait for step, apply decay and peak hold, write back
    StScale,     // intensity times voltage
    StLevel,     // classify level, scale the difference down
    StLevelDiv,  // reciprocal multiply for the level byte
    StEmit       // hand command to the output register
  } state_e;

  localparam int unsigned SumW = 5 + $clog2(ChannelsPerUnit) + 1;

  state_e state_q, state_d;

  // item fields
  logic [4:0]      unit_q;
  logic [4:0]      chan_q;
  logic [15:0]     elapsed_q;
  logic [15:0]     fade_q;
  logic [15:0]     gain_q;
  logic [15:0]     sample_q;
  logic [15:0]     minlvl_q;
  logic [7:0]      volts_q;
  logic            effect_q;
  logic [15:0]     effval_q;
  logic [IdxW-1:0] idx_q;

  // working registers
  logic [15:0] cur_q, cur_d;
  logic [31:0] prod_q;
  logic [23:0] n_q;
  logic [13:0] lvl_x_q;
  logic [7:0]  level_q, level_d;

  logic            accept;
  logic [SumW-1:0] idx_sum;
  logic [IdxW-1:0] idx_in;
  logic [15:0]     fade_eff;
  logic [15:0]     rdata;
  logic            mem_ready;
  mem_req_t        mem_req;
  div_req_t        div_req;
  div_rsp_t        div_rsp;
  logic            frm_free;
  logic            frm_load;
  frame_t          frame;

  logic [15:0] cur_dec;
  logic [22:0] prod_v;
  logic [15:0] cur_new;
  logic [22:0] diff_d;
  logic [29:0] diff_x100;
  logic [30:0] diff_x200;
  logic [28:0] lvl_prod;
  logic        n_full;

  assign accept     = in_valid_i & in_ready_o;
  assign in_ready_o = (state_q == StIdle) & mem_ready;

  // table index wraps at the (power of two) table depth
  assign idx_sum = SumW'(unit_number_i) * SumW'(ChannelsPerUnit) + SumW'(channel_number_i);
  assign idx_in  = idx_sum[IdxW-1:0];

  assign fade_eff = (fade_q < MinFade) ? MinFade : fade_q;

  // linear decay of a positive intensity, floored at zero
  always_comb begin
    cur_dec = cur_q;
    if (cur_q != 16'd0) begin
      if (div_rsp.quotient >= DvdW'(cur_q)) begin
        cur_dec = 16'd0;
      end else begin
        cur_dec = cur_q - div_rsp.quotient[15:0];
      end
    end
  end

  // effect override or peak hold of gain * sample (Q8.24 down to Q1.15)
  assign prod_v = prod_q[31:9];
  always_comb begin
    cur_new = cur_dec;
    if (effect_q) begin
      cur_new = (effval_q > OneQ15) ? OneQ15 : effval_q;
    end else if (prod_v > {7'd0, cur_dec}) begin
      if (prod_v > {7'd0, OneQ15}) begin
        cur_new = OneQ15;
      end else if (prod_v > {7'd0, minlvl_q}) begin
        cur_new = prod_v[15:0];
      end
    end
  end

  // level byte: d = full scale minus intensity * voltage
  assign n_full    = (n_q >= {1'b0, FullScale});
  assign diff_d    = FullScale - n_q[22:0];
  assign diff_x100 = 30'(diff_d) * 30'd100;
  assign diff_x200 = 31'(diff_d) * 31'd200;

  // 200*d / (220 * 2^15) = floor((200*d >> 17) / 55); the shifted value stays
  // below 2^14, where 19066 / 2^20 gives the exact quotient by 55
  assign lvl_prod = 29'(lvl_x_q) * 29'(Recip55);

  // memory port: read at accept, write back after the update
  always_comb begin
    mem_req.rd_en = accept;
    mem_req.wr_en = (state_q == StDecay) & div_rsp.done;
    mem_req.addr  = (state_q == StIdle) ? idx_in : idx_q;
    mem_req.wdata = cur_new;
  end

  // decay divider: step = elapsed * one / fade
  always_comb begin
    div_req.start    = (state_q == StRead);
    div_req.dividend = {elapsed_q, 15'd0};
    div_req.divisor  = fade_eff;
  end

  always_comb begin
    state_d = state_q;
    cur_d   = cur_q;
    level_d = level_q;
    unique case (state_q)
      StIdle: begin
        if (accept) state_d = StRead;
      end
      StRead: begin
        cur_d   = rdata;
        state_d = StDecay;
      end
      StDecay: begin
        if (div_rsp.done) begin
          cur_d   = cur_new;
          state_d = StScale;
        end
      end
      StScale: begin
        state_d = StLevel;
      end
      StLevel: begin
        if (n_full) begin
          level_d = LevelFull;
          state_d = StEmit;
        end else if (diff_x100 > FullScale99) begin
          level_d = LevelDark;
          state_d = StEmit;
        end else if (diff_x100 < {7'd0, FullScale}) begin
          level_d = LevelFull;
          state_d = StEmit;
        end else begin
          state_d = StLevelDiv;
        end
      end
      StLevelDiv: begin
        level_d = 8'(lvl_prod >> 20) + LevelBase;
        state_d = StEmit;
      end
      StEmit: begin
        if (frm_free) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      unit_q    <= unit_number_i;
      chan_q    <= channel_number_i;
      elapsed_q <= elapsed_ms_i;
      fade_q    <= fade_ms_i;
      gain_q    <= gain_q8_i;
      sample_q  <= sample_q16_i;
      minlvl_q  <= min_level_q15_i;
      volts_q   <= voltage_i;
      effect_q  <= effect_active_i;
      effval_q  <= effect_value_q15_i;
      idx_q     <= idx_in;
    end
    if (state_q == StRead) begin
      prod_q <= gain_q * sample_q;
    end
    if (state_q == StScale) begin
      n_q <= cur_q * volts_q;
    end
    if (state_q == StLevel) begin
      lvl_x_q <= 14'(diff_x200 >> 17);
    end
    cur_q   <= cur_d;
    level_q <= level_d;
  end

  assign frm_load        = (state_q == StEmit);
  assign frame.unit      = unit_q;
  assign frame.level     = level_q;
  assign frame.chan_code = chan_q[3:0] - 4'd1;   // channel zero wraps to 0x0F

  lcdfe_mem u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (rdata),
    .ready_o (mem_ready)
  );

  lcdfe_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  lcdfe_frm u_frm (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (frm_load),
    .frame_i      (frame),
    .free_o       (frm_free),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .frame_byte_o (frame_byte_o),
    .frame_last_o (frame_last_o)
  );

endmodule

`default_nettype wire

>>> rtl/lcdfe_chk.sv
// lcdfe_chk: port-level assertions for the light channel block, bound to the top level
// depends on lcdfe_pkg for frame byte constants
`default_nettype none

module lcdfe_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [4:0]  unit_number_i,
  input logic [4:0]  channel_number_i,
  input logic [15:0] elapsed_ms_i,
  input logic [15:0] fade_ms_i,
  input logic [15:0] gain_q8_i,
  input logic [15:0] sample_q16_i,
  input logic [15:0] min_level_q15_i,
  input logic [7:0]  voltage_i,
  input logic        effect_active_i,
  input logic [15:0] effect_value_q15_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  frame_byte_o,
  input logic        frame_last_o
);
  import lcdfe_pkg::*;

  // one item at a time: an accept always closes the input for a while
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input ready right after an accepted item");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(frame_byte_o) && $stable(frame_last_o)))
    else $error("stalled output byte changed");

  a_tail_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_last_o) |-> (frame_byte_o == FrameTail))
    else $error("last byte of a command is not the tail byte");

  // a command that follows a finished one opens with the header byte
  a_next_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && frame_last_o) |=>
      (!out_valid_o || (frame_byte_o == FrameHdr && !frame_last_o)))
    else $error("command does not start with the header byte");

endmodule

bind light_channel_decay_and_frame_encode lcdfe_chk u_lcdfe_chk (.*);

`default_nettype wire

>>> dv/light_channel_decay_and_frame_encode_test.sv
`timescale 1ns / 1ps
// light_channel_decay_and_frame_encode_test: self-checking bench for the light channel block
// drives channel updates, predicts the six-byte dimmer commands and checks every byte
// depends on lcdfe_pkg and light_channel_decay_and_frame_encode

module light_channel_decay_and_frame_encode_test;
  import lcdfe_pkg::*;

  // run shape
  localparam int unsigned CycleLimit     = 500000;
  localparam int unsigned DrainCycles    = 100;
  localparam int unsigned RandomUpdates  = 428;
  localparam int unsigned CalmUpdates    = 60;
  localparam int unsigned HoldCycles     = 600;
  localparam int unsigned HoldAfterBytes = 240;
  localparam int unsigned HotChannels    = 8;

  typedef struct packed {
    logic [4:0]  unit;
    logic [4:0]  chan;
    logic [15:0] elapsed;
    logic [15:0] fade;
    logic [15:0] gain;
    logic [15:0] sample;
    logic [15:0] min_level;
    logic [7:0]  voltage;
    logic        effect;
    logic [15:0] effect_value;
  } chan_update_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_beat_t;

  // keeps its own intensity table and the queue of command bytes still owed
  class frame_predictor;
    logic [15:0]  intensity [TableDepth];
    frame_beat_t  owed_beats [$];
    int unsigned  mismatches;

    function new();
      foreach (intensity[i]) intensity[i] = 16'd0;
      mismatches = 0;
    endfunction

    // percentage rule on I*V against 220 * one, done in integers
    function logic [7:0] level_of(longint unsigned lvl, logic [7:0] volts);
      longint unsigned n, d, fs;
      fs = longint'(FullScale);
      n  = lvl * longint'(volts);
      if (n >= fs) return LevelFull;
      d = fs - n;
      if (100 * d > 99 * fs) return LevelDark;
      if (100 * d < fs) return LevelFull;
      return 8'((200 * d) / fs + longint'(LevelBase));
    endfunction

    // append one expected byte to the tail of the queue
    function void owe_beat(logic [7:0] data, logic last);
      frame_beat_t b;
      b.data = data;
      b.last = last;
      owed_beats = {owed_beats, b};
    endfunction

    function void note_update(chan_update_t u);
      int unsigned     idx;
      longint unsigned cur, fade, step, prod;
      logic [7:0]      level;
      idx  = (int'(u.unit) * ChannelsPerUnit + int'(u.chan)) % TableDepth;
      cur  = intensity[idx];
      fade = (u.fade < MinFade) ? longint'(MinFade) : longint'(u.fade);
      // linear decay, only while lit, floored at dark
      if (cur > 0) begin
        step = (longint'(u.elapsed) * longint'(OneQ15)) / fade;
        cur  = (step >= cur) ? 0 : cur - step;
      end
      if (u.effect) begin
        cur = (u.effect_value > OneQ15) ? longint'(OneQ15) : longint'(u.effect_value);
      end else begin
        // peak hold of gain * sample in Q1.15
        prod = (longint'(u.gain) * longint'(u.sample)) >> 9;
        if (prod > cur) begin
          if (prod > longint'(OneQ15)) cur = longint'(OneQ15);
          else if (prod > longint'(u.min_level)) cur = prod;
        end
      end
      intensity[idx] = 16'(cur);
      level = level_of(cur, u.voltage);
      owe_beat(FrameHdr, 1'b0);
      owe_beat({3'b000, u.unit}, 1'b0);
      owe_beat(FrameCmd, 1'b0);
      owe_beat(level, 1'b0);
      owe_beat({FrameChanFlag, 4'(u.chan - 5'd1)}, 1'b0);
      owe_beat(FrameTail, 1'b1);
    endfunction

    function void check_beat(logic [7:0] data, logic last);
      frame_beat_t want;
      if (owed_beats.size() == 0) begin
        $error("unexpected frame byte %02h last %0b", data, last);
        mismatches++;
        return;
      end
      want = owed_beats.pop_front();
      if (data !== want.data) begin
        $error("frame_byte expected %02h actual %02h", want.data, data);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("frame_last expected %0b actual %0b", want.last, last);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return owed_beats.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [4:0]  unit_number_i;
  logic [4:0]  channel_number_i;
  logic [15:0] elapsed_ms_i;
  logic [15:0] fade_ms_i;
  logic [15:0] gain_q8_i;
  logic [15:0] sample_q16_i;
  logic [15:0] min_level_q15_i;
  logic [7:0]  voltage_i;
  logic        effect_active_i;
  logic [15:0] effect_value_q15_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  frame_byte_o;
  logic        frame_last_o;

  // set for the tail of the run: no idling on either side
  bit calm = 1'b0;

  frame_predictor sb = new();

  light_channel_decay_and_frame_encode u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .unit_number_i     (unit_number_i),
    .channel_number_i  (channel_number_i),
    .elapsed_ms_i      (elapsed_ms_i),
    .fade_ms_i         (fade_ms_i),
    .gain_q8_i         (gain_q8_i),
    .sample_q16_i      (sample_q16_i),
    .min_level_q15_i   (min_level_q15_i),
    .voltage_i         (voltage_i),
    .effect_active_i   (effect_active_i),
    .effect_value_q15_i(effect_value_q15_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .frame_byte_o      (frame_byte_o),
    .frame_last_o      (frame_last_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic chan_update_t upd(
    logic [4:0] unit, logic [4:0] chan, logic [15:0] elapsed, logic [15:0] fade,
    logic [15:0] gain, logic [15:0] sample, logic [15:0] min_level, logic [7:0] voltage,
    logic effect, logic [15:0] effect_value);
    return '{unit, chan, elapsed, fade, gain, sample, min_level, voltage, effect,
             effect_value};
  endfunction

  // offer one item, hold it until accepted, then maybe idle for a burst
  task automatic send_update(input chan_update_t u);
    in_valid_i         <= 1'b1;
    unit_number_i      <= u.unit;
    channel_number_i   <= u.chan;
    elapsed_ms_i       <= u.elapsed;
    fade_ms_i          <= u.fade;
    gain_q8_i          <= u.gain;
    sample_q16_i       <= u.sample;
    min_level_q15_i    <= u.min_level;
    voltage_i          <= u.voltage;
    effect_active_i    <= u.effect;
    effect_value_q15_i <= u.effect_value;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_update(u);
    if (!calm && $urandom_range(0, 2) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // sender and end of run
  initial begin : stimulus
    chan_update_t u;
    logic [4:0]   hot_unit [HotChannels];
    logic [4:0]   hot_chan [HotChannels];
    int unsigned  sel;

    rst_ni             <= 1'b0;
    in_valid_i         <= 1'b0;
    unit_number_i      <= '0;
    channel_number_i   <= '0;
    elapsed_ms_i       <= '0;
    fade_ms_i          <= '0;
    gain_q8_i          <= '0;
    sample_q16_i       <= '0;
    min_level_q15_i    <= '0;
    voltage_i          <= '0;
    effect_active_i    <= 1'b0;
    effect_value_q15_i <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: all zero, fade below the floor
    send_update(upd(0, 1, 0, 0, 0, 0, 0, 0, 0, 0));
    // product saturates at one, full voltage gives the brightest byte
    send_update(upd(31, 16, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 255, 0, 0));
    // long elapsed on a lit channel floors at dark
    send_update(upd(31, 16, 16'hFFFF, 100, 0, 0, 0, 220, 0, 0));
    // effect above one saturates, I*V exactly at full scale
    send_update(upd(31, 16, 0, 100, 0, 0, 0, 220, 1, 16'hFFFF));
    // partial decay, mid level
    send_update(upd(31, 16, 50, 1000, 0, 0, 0, 110, 0, 0));
    // channel zero wraps the channel code
    send_update(upd(5, 0, 0, 100, 256, 16'h8000, 0, 220, 0, 0));
    // top channel number, effect forcing dark
    send_update(upd(5, 31, 0, 100, 0, 0, 0, 255, 1, 0));
    // minimum level above one blocks an unsaturated product
    send_update(upd(7, 3, 0, 100, 256, 16'h8000, 16'hFFFF, 220, 0, 0));
    // product equal to minimum is refused, one above is taken
    send_update(upd(7, 4, 0, 100, 256, 16'h4000, 8192, 220, 0, 0));
    send_update(upd(7, 4, 0, 100, 512, 8193, 8192, 220, 0, 0));
    // product below the held peak keeps the peak, zero volts
    send_update(upd(7, 4, 0, 100, 512, 8000, 0, 0, 0, 0));
    // level byte edges around one and ninety-nine percent
    send_update(upd(9, 9, 0, 100, 0, 0, 0, 1, 1, 16'h8000));
    send_update(upd(9, 9, 0, 100, 0, 0, 0, 218, 1, 16'h8000));
    send_update(upd(9, 9, 0, 100, 0, 0, 0, 217, 1, 16'h8000));
    send_update(upd(9, 10, 0, 100, 0, 0, 0, 100, 1, 16'h8001));
    // full-width decay step exactly one
    send_update(upd(9, 9, 16'hFFFF, 16'hFFFF, 0, 0, 0, 217, 0, 0));
    // product just under one, equal to the minimum
    send_update(upd(16, 8, 0, 100, 16'h0100, 16'hFFFF, 16'h7FFF, 200, 0, 0));
    // fade of 99 behaves like 100
    send_update(upd(3, 2, 0, 100, 0, 0, 0, 200, 1, 16'h8000));
    send_update(upd(3, 2, 1, 99, 0, 0, 0, 200, 0, 0));
    send_update(upd(3, 2, 1, 100, 0, 0, 0, 200, 0, 0));
    // alternating bit patterns on every field
    send_update(upd(21, 21, 16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 16'h5555, 8'hAA, 1,
                    16'h5555));
    send_update(upd(10, 10, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 16'hAAAA, 8'h55, 0,
                    16'hAAAA));

    // a few hot channels get most updates so decay and peak hold build up
    foreach (hot_unit[k]) begin
      hot_unit[k] = 5'($urandom_range(0, 31));
      hot_chan[k] = 5'($urandom_range(1, 16));
    end
    hot_chan[0] = 5'd0;

    for (int n = 0; n < RandomUpdates; n++) begin
      if (n == RandomUpdates - CalmUpdates) calm <= 1'b1;
      sel = $urandom_range(0, HotChannels - 1);
      if ($urandom_range(0, 3) != 0) begin
        u.unit = hot_unit[sel];
        u.chan = hot_chan[sel];
      end else begin
        u.unit = 5'($urandom);
        u.chan = ($urandom_range(0, 7) == 0) ? 5'($urandom) : 5'($urandom_range(1, 16));
      end
      u.elapsed = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 150));
      case ($urandom_range(0, 3))
        0:       u.fade = 16'($urandom);
        1:       u.fade = 16'($urandom_range(0, 99));
        default: u.fade = 16'($urandom_range(100, 3000));
      endcase
      u.gain   = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 512));
      u.sample = 16'($urandom);
      case ($urandom_range(0, 3))
        0:       u.min_level = 16'($urandom);
        1:       u.min_level = 16'd0;
        default: u.min_level = 16'($urandom_range(0, 32768));
      endcase
      u.voltage = ($urandom_range(0, 1) == 0) ? 8'($urandom) : 8'($urandom_range(100, 240));
      u.effect  = ($urandom_range(0, 4) == 0);
      u.effect_value = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(0, 32768));
      send_update(u);
    end
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[light_channel_decay_and_frame_encode] OK");
    end else begin
      $display("[light_channel_decay_and_frame_encode] ERROR");
    end
    $finish;
  end

  // receiver: checks each accepted byte, stalls in bursts, and once holds off
  // long enough that the command register fills and the input stalls
  initial begin : receiver
    int unsigned stall_left;
    int unsigned hold_left;
    int unsigned beats_seen;
    bit          held;
    stall_left = 0;
    hold_left  = 0;
    beats_seen = 0;
    held       = 1'b0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        sb.check_beat(frame_byte_o, frame_last_o);
        beats_seen++;
      end
      if (!held && beats_seen >= HoldAfterBytes) begin
        held      = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // watchdog on total run length
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("[light_channel_decay_and_frame_encode] ERROR");
    $finish;
  end

endmodule
